@@ hdl/ths_pkg.sv @@
// Shared types and constants for the top-k heap selector.
// Request, result and heap entry layouts plus the compare unit's status.
// No dependencies.
`default_nettype none

package ths_pkg;

  // Fixed field widths
  localparam int unsigned ScoreBits = 32;
  localparam int unsigned CoordBits = 8;
  localparam int unsigned KBits     = 5;

  // Value that k_best takes at reset
  localparam logic [KBits-1:0] KBestReset = KBits'(16);

  // Request kinds
  localparam logic KindOffer = 1'b0;
  localparam logic KindDrain = 1'b1;

  // One request: offer a scored item or drain the kept ones
  typedef struct packed {
    logic                        kind;
    logic signed [ScoreBits-1:0] score;
    logic [CoordBits-1:0]        row_start;
    logic [CoordBits-1:0]        col_start;
    logic [CoordBits-1:0]        row_end;
    logic [CoordBits-1:0]        col_end;
  } ths_req_t;

  // One result of a drain
  typedef struct packed {
    logic signed [ScoreBits-1:0] out_score;
    logic [CoordBits-1:0]        out_row_start;
    logic [CoordBits-1:0]        out_col_start;
    logic [CoordBits-1:0]        out_row_end;
    logic [CoordBits-1:0]        out_col_end;
    logic                        is_last;
    logic                        empty_res;
  } ths_res_t;

  // One kept heap entry
  typedef struct packed {
    logic signed [ScoreBits-1:0] score;
    logic [CoordBits-1:0]        row_start;
    logic [CoordBits-1:0]        col_start;
    logic [CoordBits-1:0]        row_end;
    logic [CoordBits-1:0]        col_end;
  } ths_entry_t;

  localparam int unsigned EntryBits = $bits(ths_entry_t);

  // Compare unit status
  typedef struct packed {
    logic worse;     // a ranks strictly below b
    logic score_lt;  // a's score strictly below b's
  } ths_cmp_t;

endpackage

`default_nettype wire

@@ hdl/top_k_heap_selector.sv @@
// Top-k heap selector: sequencer, heap RAM and shared rank compare unit.
// Depends on ths_pkg, ths_ram and ths_rank.
//
// Usage:
//   Requests enter on in_valid_i / in_stall_o / in_req_i; a request is taken
//   at a clock edge with in_valid_i high and in_stall_o low. Results leave on
//   out_valid_o / out_stall_i / out_res_o through one output register.
//   The user must write k_best through cfg_we_i / cfg_wdata_i only while the
//   block is idle; the block itself does not enforce this. An offer while the
//   heap is below capacity walks up the heap, reading and comparing the parent
//   at each level. An offer on a full heap reads the root and, when it wins,
//   walks down, picking the worse child and comparing at each level. A drain
//   of n entries emits best first; each result is found by a scan of the heap
//   RAM, one entry per cycle. A drain of an empty heap gives one result flagged
//   empty. Rate is set by the single compare unit and the RAM ports.
//   in_stall_o is high while a request is being worked on. When the receiver
//   stalls, the held result stays and the drain waits for the register.
//   Reset empties the heap and sets k_best to 16; the RAM is not cleared.
`default_nettype none

module top_k_heap_selector #(
  parameter int unsigned HEAP_DEPTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [ths_pkg::KBits-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire ths_pkg::ths_req_t         in_req_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output ths_pkg::ths_res_t              out_res_o
);
  import ths_pkg::*;

  localparam int unsigned IdxW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(HEAP_DEPTH + 1);

  // Sequencer states
  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SUpRd    = 4'd1;
  localparam logic [3:0] SUpCmp   = 4'd2;
  localparam logic [3:0] SRootRd  = 4'd3;
  localparam logic [3:0] SRootCmp = 4'd4;
  localparam logic [3:0] SDnRd    = 4'd5;
  localparam logic [3:0] SDnPick  = 4'd6;
  localparam logic [3:0] SDnCmp   = 4'd7;
  localparam logic [3:0] SScan    = 4'd8;
  localparam logic [3:0] SEmit    = 4'd9;
  localparam logic [3:0] SEmpty   = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [KBits-1:0]      kb_q;
  logic                  out_vld_q, out_vld_d;
  ths_res_t              out_res_q, out_res_d;
  logic [HEAP_DEPTH-1:0] sent_q, sent_d;

  ths_entry_t            cur_q, cur_d;
  ths_entry_t            sel_q, sel_d;
  ths_entry_t            best_q, best_d;
  logic [IdxW-1:0]       hole_q, hole_d;
  logic [IdxW-1:0]       selidx_q, selidx_d;
  logic [IdxW-1:0]       bidx_q, bidx_d;
  logic                  bvld_q, bvld_d;
  logic [CntW-1:0]       scan_q, scan_d;
  logic                  pv_q, pv_d;
  logic [IdxW-1:0]       pidx_q, pidx_d;
  logic [CntW-1:0]       emit_q, emit_d;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  ths_entry_t            ram_wdata;
  logic [IdxW-1:0]       raddr_a;
  logic [IdxW-1:0]       raddr_b;
  logic [EntryBits-1:0]  rdata_a_raw;
  logic [EntryBits-1:0]  rdata_b_raw;
  ths_entry_t            rd_a;
  ths_entry_t            rd_b;

  ths_entry_t            cmp_a;
  ths_entry_t            cmp_b;
  ths_cmp_t              cmp;

  logic [CntW-1:0]       cap;
  logic                  in_acc;
  logic                  out_free;
  logic [IdxW-1:0]       parent;
  logic [IdxW+1:0]       child;
  logic [IdxW+1:0]       child_b;
  logic [IdxW+1:0]       cnt_ext;
  ths_entry_t            req_entry;

  // Heap storage
  ths_ram #(
    .Width (EntryBits),
    .Depth (HEAP_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a_raw),
    .rdata_b_o (rdata_b_raw)
  );

  assign rd_a = ths_entry_t'(rdata_a_raw);
  assign rd_b = ths_entry_t'(rdata_b_raw);

  // Shared compare unit
  ths_rank u_rank (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  // Saturate k_best into 1..HEAP_DEPTH
  always_comb begin
    if (kb_q == '0) begin
      cap = CntW'(1);
    end else if (int'(kb_q) > int'(HEAP_DEPTH)) begin
      cap = CntW'(HEAP_DEPTH);
    end else begin
      cap = CntW'(kb_q);
    end
  end

  assign in_stall_o = (state_q != SIdle);
  assign in_acc     = in_valid_i && (state_q == SIdle);
  assign out_free   = !out_vld_q || !out_stall_i;

  // Heap index arithmetic
  assign parent  = IdxW'((hole_q - IdxW'(1)) >> 1);
  assign child   = {1'b0, hole_q, 1'b1};
  assign child_b = child + (IdxW+2)'(1);
  assign cnt_ext = (IdxW+2)'(cnt_q);

  assign req_entry.score     = in_req_i.score;
  assign req_entry.row_start = in_req_i.row_start;
  assign req_entry.col_start = in_req_i.col_start;
  assign req_entry.row_end   = in_req_i.row_end;
  assign req_entry.col_end   = in_req_i.col_end;

  // Steer the compare unit's operands
  always_comb begin
    cmp_a = cur_q;
    cmp_b = rd_a;
    case (state_q)
      SUpCmp: begin
        cmp_a = cur_q;
        cmp_b = rd_a;
      end
      SRootCmp: begin
        cmp_a = rd_a;
        cmp_b = cur_q;
      end
      SDnPick: begin
        cmp_a = rd_b;
        cmp_b = rd_a;
      end
      SDnCmp: begin
        cmp_a = sel_q;
        cmp_b = cur_q;
      end
      SScan: begin
        cmp_a = best_q;
        cmp_b = rd_a;
      end
      default: begin
        cmp_a = cur_q;
        cmp_b = rd_a;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    sent_d    = sent_q;
    cur_d     = cur_q;
    sel_d     = sel_q;
    selidx_d  = selidx_q;
    best_d    = best_q;
    bidx_d    = bidx_q;
    bvld_d    = bvld_q;
    hole_d    = hole_q;
    scan_d    = scan_q;
    pv_d      = pv_q;
    pidx_d    = pidx_q;
    emit_d    = emit_q;
    ram_we    = 1'b0;
    ram_waddr = hole_q;
    ram_wdata = cur_q;
    raddr_a   = '0;
    raddr_b   = '0;
    out_res_d = out_res_q;
    out_vld_d = out_vld_q && out_stall_i;

    case (state_q)
      SIdle: begin
        if (in_acc) begin
          cur_d = req_entry;
          if (in_req_i.kind == KindOffer) begin
            if (cnt_q < cap) begin
              // Append at the end and walk up
              hole_d  = cnt_q[IdxW-1:0];
              cnt_d   = cnt_q + CntW'(1);
              state_d = SUpRd;
            end else begin
              state_d = SRootRd;
            end
          end else if (cnt_q == '0) begin
            state_d = SEmpty;
          end else begin
            sent_d  = '0;
            scan_d  = '0;
            pv_d    = 1'b0;
            bvld_d  = 1'b0;
            emit_d  = '0;
            state_d = SScan;
          end
        end
      end

      SUpRd: begin
        if (hole_q == '0) begin
          ram_we  = 1'b1;
          state_d = SIdle;
        end else begin
          raddr_a = parent;
          state_d = SUpCmp;
        end
      end

      SUpCmp: begin
        ram_we = 1'b1;
        if (cmp.worse) begin
          // Pull the parent down into the hole
          ram_wdata = rd_a;
          hole_d    = parent;
          state_d   = SUpRd;
        end else begin
          state_d = SIdle;
        end
      end

      SRootRd: begin
        raddr_a = '0;
        state_d = SRootCmp;
      end

      SRootCmp: begin
        if (cmp.score_lt) begin
          hole_d  = '0;
          state_d = SDnRd;
        end else begin
          state_d = SIdle;
        end
      end

      SDnRd: begin
        if (child >= cnt_ext) begin
          ram_we  = 1'b1;
          state_d = SIdle;
        end else begin
          raddr_a = child[IdxW-1:0];
          raddr_b = child_b[IdxW-1:0];
          state_d = SDnPick;
        end
      end

      SDnPick: begin
        // Pick the worse child
        if ((child_b < cnt_ext) && cmp.worse) begin
          sel_d    = rd_b;
          selidx_d = child_b[IdxW-1:0];
        end else begin
          sel_d    = rd_a;
          selidx_d = child[IdxW-1:0];
        end
        state_d = SDnCmp;
      end

      SDnCmp: begin
        ram_we = 1'b1;
        if (cmp.worse) begin
          // Lift the child into the hole
          ram_wdata = sel_q;
          hole_d    = selidx_q;
          state_d   = SDnRd;
        end else begin
          state_d = SIdle;
        end
      end

      SScan: begin
        // Keep the best entry not yet emitted
        if (pv_q && !sent_q[pidx_q] && (!bvld_q || cmp.worse)) begin
          best_d = rd_a;
          bidx_d = pidx_q;
          bvld_d = 1'b1;
        end
        if (scan_q < cnt_q) begin
          raddr_a = scan_q[IdxW-1:0];
          pv_d    = 1'b1;
          pidx_d  = scan_q[IdxW-1:0];
          scan_d  = scan_q + CntW'(1);
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            state_d = SEmit;
          end
        end
      end

      SEmit: begin
        if (out_free) begin
          out_vld_d               = 1'b1;
          out_res_d.out_score     = best_q.score;
          out_res_d.out_row_start = best_q.row_start;
          out_res_d.out_col_start = best_q.col_start;
          out_res_d.out_row_end   = best_q.row_end;
          out_res_d.out_col_end   = best_q.col_end;
          out_res_d.is_last       = (emit_q == cnt_q - CntW'(1));
          out_res_d.empty_res     = 1'b0;
          sent_d[bidx_q]          = 1'b1;
          if (emit_q == cnt_q - CntW'(1)) begin
            cnt_d   = '0;
            state_d = SIdle;
          end else begin
            emit_d  = emit_q + CntW'(1);
            scan_d  = '0;
            pv_d    = 1'b0;
            bvld_d  = 1'b0;
            state_d = SScan;
          end
        end
      end

      SEmpty: begin
        if (out_free) begin
          out_vld_d           = 1'b1;
          out_res_d           = '0;
          out_res_d.is_last   = 1'b1;
          out_res_d.empty_res = 1'b1;
          state_d             = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cnt_q     <= '0;
      kb_q      <= KBestReset;
      out_vld_q <= 1'b0;
      sent_q    <= '0;
      bvld_q    <= 1'b0;
      pv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      sent_q    <= sent_d;
      bvld_q    <= bvld_d;
      pv_q      <= pv_d;
      if (cfg_we_i) begin
        kb_q <= cfg_wdata_i;
      end
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    cur_q     <= cur_d;
    sel_q     <= sel_d;
    selidx_q  <= selidx_d;
    best_q    <= best_d;
    bidx_q    <= bidx_d;
    hole_q    <= hole_d;
    scan_q    <= scan_d;
    pidx_q    <= pidx_d;
    emit_q    <= emit_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

@@ hdl/ths_ram.sv @@
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
`default_nettype none

module ths_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, and register both reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

@@ hdl/ths_rank.sv @@
// Shared rank compare unit for heap entries: higher score ranks better,
// equal scores fall back to the lower tag. Depends on ths_pkg.
`default_nettype none

module ths_rank (
  input  wire ths_pkg::ths_entry_t a_i,
  input  wire ths_pkg::ths_entry_t b_i,
  output ths_pkg::ths_cmp_t        res_o
);
  import ths_pkg::*;

  logic [4*CoordBits-1:0] tag_a;
  logic [4*CoordBits-1:0] tag_b;

  // Tag compares lexicographically in field order
  assign tag_a = {a_i.row_start, a_i.col_start, a_i.row_end, a_i.col_end};
  assign tag_b = {b_i.row_start, b_i.col_start, b_i.row_end, b_i.col_end};

  assign res_o.score_lt = (a_i.score < b_i.score);
  assign res_o.worse    = (a_i.score < b_i.score) ||
                          ((a_i.score == b_i.score) && (tag_a > tag_b));

endmodule

`default_nettype wire
